@@ hdl/tfi_pkg.sv @@
// Package for the table function interpolator: payload structs, status codes,
// command codes and defaults. No dependencies.
package tfi_pkg;

	localparam int unsigned DefMaxPoints = 64;
	localparam int unsigned DefValueBits = 32;
	localparam int unsigned IoBits = 32;
	localparam int unsigned CfgIdxBits = 1;
	localparam int unsigned CfgDataBits = 7;

	localparam logic [CfgIdxBits-1:0] CFG_INTERP_MODE = 1'd0;
	localparam logic [CfgIdxBits-1:0] CFG_POINTS_IN_USE = 1'd1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic kind;
		logic [5:0] point_index;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
	} tfi_in_t;

	typedef struct packed {
		logic signed [31:0] y_result;
		logic [5:0] interval;
		logic clamped;
		logic [1:0] status;
	} tfi_out_t;

	// Start/done pair between the sequencer and the divider.
	typedef struct packed {
		logic start;
		logic done;
	} tfi_div_ctl_t;

endpackage

@@ hdl/tfi_mem.sv @@
// Breakpoint store: one synchronous memory of (x, y) pairs, one read port
// with registered data and one write port. Uses tfi_pkg.
module tfi_mem import tfi_pkg::*; #(
	parameter int unsigned MAX_POINTS = DefMaxPoints,
	parameter int unsigned VALUE_BITS = DefValueBits,
	localparam int unsigned AW = $clog2(MAX_POINTS)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [2*VALUE_BITS-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic [2*VALUE_BITS-1:0] rdata
);

	logic [2*VALUE_BITS-1:0] mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/tfi_div.sv @@
// Bit-serial multiply-divide: floor(a*b/d) for a < d, one bit of b per
// cycle. Uses tfi_pkg.
module tfi_div import tfi_pkg::*; #(
	parameter int unsigned VALUE_BITS = DefValueBits,
	localparam int unsigned W = VALUE_BITS + 1,
	localparam int unsigned CW = $clog2(W + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] d,
	output logic         done,
	output logic [W-1:0] q
);

	logic         busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] a_q, b_q, d_q, r_q;
	logic [W:0]   r1, r2;
	logic [W-1:0] r1m, r2m;
	logic         q1, q2;

	always_comb begin
		r1 = {r_q, 1'b0};
		q1 = r1 >= {1'b0, d_q};
		r1m = q1 ? W'(r1 - {1'b0, d_q}) : r1[W-1:0];
		r2 = b_q[W-1] ? ({1'b0, r1m} + {1'b0, a_q}) : {1'b0, r1m};
		q2 = b_q[W-1] && (r2 >= {1'b0, d_q});
		r2m = q2 ? W'(r2 - {1'b0, d_q}) : r2[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			d_q <= d;
			r_q <= '0;
			q <= '0;
		end else if (busy_q) begin
			r_q <= r2m;
			b_q <= {b_q[W-2:0], 1'b0};
			q <= W'({q, 1'b0} + W'(q1) + W'(q2));
		end
	end

endmodule

@@ hdl/tfi_seq.sv @@
// Sequencer: loads, end checks, binary search over the breakpoint memory and
// the final combine. Uses tfi_pkg, drives tfi_mem and tfi_div.
module tfi_seq import tfi_pkg::*; #(
	parameter int unsigned MAX_POINTS = DefMaxPoints,
	parameter int unsigned VALUE_BITS = DefValueBits,
	localparam int unsigned AW = $clog2(MAX_POINTS),
	localparam int unsigned NW = $clog2(MAX_POINTS + 1) > 7 ? $clog2(MAX_POINTS + 1) : 7,
	localparam int unsigned W = VALUE_BITS + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  tfi_in_t                 in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output tfi_out_t                out_data,
	input  logic                    mode,
	input  logic [6:0]              npts,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output logic [2*VALUE_BITS-1:0] mem_wdata,
	output logic [AW-1:0]           mem_raddr,
	input  logic [2*VALUE_BITS-1:0] mem_rdata,
	output tfi_div_ctl_t            dctl_start,
	input  tfi_div_ctl_t            dctl_done,
	output logic [W-1:0]            div_a,
	output logic [W-1:0]            div_b,
	output logic [W-1:0]            div_d,
	input  logic [W-1:0]            div_q
);

	typedef enum logic [3:0] {
		S_IDLE, S_LCHK, S_FIRST, S_LAST, S_PROBE, S_LEFT, S_RIGHT, S_DIV, S_OUT
	} state_t;

	typedef logic signed [VALUE_BITS-1:0] val_t;

	state_t state_q;
	logic   bad_q;
	logic [AW-1:0] idx_q, lo_q, hi_q;
	val_t   x_q, yin_q, x1_q, y1_q;
	logic   neg_q;
	tfi_out_t res_q;

	val_t rx, ry;
	logic [AW:0] n_ext;
	logic [AW-1:0] last;
	logic [AW-1:0] mid;
	val_t xin, yin;

	assign rx = mem_rdata[2*VALUE_BITS-1:VALUE_BITS];
	assign ry = mem_rdata[VALUE_BITS-1:0];
	assign n_ext = (AW + 1)'(npts);
	assign last = AW'(n_ext - 1'b1);
	assign mid = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign xin = val_t'(in_data.x_value);
	assign yin = val_t'(in_data.y_value);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;
	assign mem_we = (state_q == S_LCHK);
	assign mem_waddr = idx_q;
	assign mem_wdata = {x_q, yin_q};
	assign dctl_start = '{start: (state_q == S_RIGHT) && !mode, done: 1'b0};

	always_comb begin
		case (state_q)
			S_IDLE:  mem_raddr = (in_data.kind == KIND_EVAL) ? '0 : AW'(in_data.point_index - 1'b1);
			S_FIRST: mem_raddr = last;
			S_LAST:  mem_raddr = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
			S_PROBE: mem_raddr = (hi_q - lo_q > AW'(1)) ?
				AW'(({1'b0, (rx <= x_q) ? mid : lo_q} + {1'b0, (rx <= x_q) ? hi_q : mid}) >> 1) : lo_q;
			S_LEFT:  mem_raddr = lo_q + 1'b1;
			default: mem_raddr = lo_q;
		endcase
	end

	// Linear term: a = x - x1, d = x2 - x1, b = |y2 - y1|, all in W bits.
	assign div_a = W'(x_q) - W'(x1_q);
	assign div_d = W'(rx) - W'(x1_q);
	assign div_b = (y1_q <= ry) ? W'({ry[VALUE_BITS-1], ry} - {y1_q[VALUE_BITS-1], y1_q})
		: W'({y1_q[VALUE_BITS-1], y1_q} - {ry[VALUE_BITS-1], ry});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bad_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					idx_q <= AW'(in_data.point_index);
					x_q <= xin;
					yin_q <= yin;
					res_q <= '{y_result: '0, interval: '0, clamped: 1'b0, status: ST_OK};
					if (in_data.kind == KIND_LOAD) begin
						if (32'(in_data.point_index) >= MAX_POINTS) begin
							res_q.status <= ST_RANGE;
							state_q <= S_OUT;
						end else begin
							state_q <= S_LCHK;
						end
					end else if ((NW)'(npts) > (NW)'(MAX_POINTS)) begin
						res_q.status <= ST_RANGE;
						state_q <= S_OUT;
					end else if (npts < 7'd2) begin
						res_q.status <= ST_FEW;
						state_q <= S_OUT;
					end else if (bad_q) begin
						res_q.status <= ST_BAD;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FIRST;
					end
				end
				S_LCHK: begin
					if (idx_q == '0) begin
						bad_q <= 1'b0;
					end else if (x_q <= rx) begin
						bad_q <= 1'b1;
						res_q.status <= ST_BAD;
					end
					state_q <= S_OUT;
				end
				S_FIRST: begin
					lo_q <= '0;
					hi_q <= last;
					if (x_q <= rx) begin
						res_q.y_result <= 32'(ry);
						res_q.clamped <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (rx <= x_q) begin
						res_q.y_result <= 32'(ry);
						res_q.interval <= 6'(last);
						res_q.clamped <= 1'b1;
						state_q <= S_OUT;
					end else if (hi_q - lo_q > AW'(1)) begin
						state_q <= S_PROBE;
					end else begin
						state_q <= S_LEFT;
					end
				end
				S_PROBE: begin
					if (hi_q - lo_q > AW'(1)) begin
						if (rx <= x_q) lo_q <= mid;
						else hi_q <= mid;
						state_q <= S_PROBE;
					end else begin
						state_q <= S_LEFT;
					end
				end
				S_LEFT: begin
					x1_q <= rx;
					y1_q <= ry;
					res_q.interval <= 6'(lo_q);
					if (mode) begin
						res_q.y_result <= 32'(ry);
						state_q <= S_OUT;
					end else begin
						state_q <= S_RIGHT;
					end
				end
				S_RIGHT: begin
					neg_q <= !(y1_q <= ry);
					state_q <= S_DIV;
				end
				S_DIV: if (dctl_done.done) begin
					res_q.y_result <= 32'(neg_q ? (y1_q - val_t'(div_q)) : (y1_q + val_t'(div_q)));
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/table_function_interpolator_top.sv @@
// Top level of the table function interpolator: configuration registers and
// the wiring of tfi_seq, tfi_mem and tfi_div. Uses tfi_pkg.
//
// Channel | Signals                        | Payload
// in      | in_valid / in_ready            | in_data  (tfi_in_t)
// out     | out_valid / out_ready          | out_data (tfi_out_t)
// cfg     | cfg_we, cfg_idx, cfg_data      | interp_mode, points_in_use
//
// One item is in flight at a time. An in-range load passes through a check state
// and then offers the result beat, and the block returns to idle once the beat is
// taken. An evaluate reads the memory for the two end checks, once per probe of the
// binary search and for its interval's breakpoints, then in linear mode waits for
// the bit-serial divider. The single memory read port sets the search time.
// Reset clears the table-bad flag, the configuration registers and the control
// state; the table contents are undefined until loaded. A stalled output holds input.
module table_function_interpolator_top import tfi_pkg::*; #(
	parameter int unsigned MAX_POINTS = DefMaxPoints,
	parameter int unsigned VALUE_BITS = DefValueBits
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tfi_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tfi_out_t               out_data,
	input  logic                   cfg_we,
	input  logic [CfgIdxBits-1:0]  cfg_idx,
	input  logic [CfgDataBits-1:0] cfg_data
);

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned W = VALUE_BITS + 1;

	logic mode_q;
	logic [6:0] npts_q;

	// The user must write configuration only while idle, so plain registers suffice; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			npts_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INTERP_MODE:   mode_q <= cfg_data[0];
				CFG_POINTS_IN_USE: npts_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [2*VALUE_BITS-1:0] mem_wdata, mem_rdata;
	tfi_div_ctl_t dstart, ddone;
	logic [W-1:0] da, db, dd, dq;
	logic dfin;

	assign ddone = '{start: 1'b0, done: dfin};

	tfi_seq #(.MAX_POINTS(MAX_POINTS), .VALUE_BITS(VALUE_BITS)) u_seq (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.mode(mode_q), .npts(npts_q),
		.mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata,
		.dctl_start(dstart), .dctl_done(ddone),
		.div_a(da), .div_b(db), .div_d(dd), .div_q(dq)
	);

	tfi_mem #(.MAX_POINTS(MAX_POINTS), .VALUE_BITS(VALUE_BITS)) u_mem (
		.clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	tfi_div #(.VALUE_BITS(VALUE_BITS)) u_div (
		.clk, .arst_n, .start(dstart.start), .a(da), .b(db), .d(dd),
		.done(dfin), .q(dq)
	);

	// The block never accepts an input beat while a result is pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in_ready while result pending");

	// After an acceptance the block does not both offer a result and accept input.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid || !in_ready)
		else $error("result and acceptance overlap");

	// A divider start is never issued while it is already reporting done.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		!(dstart.start && dfin)) else $error("divider restarted while done");

endmodule

@@ test/table_function_interpolator_top_tb.sv @@
// Self-checking testbench for table_function_interpolator_top: loads breakpoint
// tables, evaluates queries, and compares every result beat to a behavioral
// predictor. Depends on tfi_pkg and the RTL top level only.
module table_function_interpolator_top_tb;
	import tfi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 64;
	localparam int ITEM_TARGET = 650;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tfi_in_t in_data;
	logic out_valid;
	logic out_ready;
	tfi_out_t out_data;
	logic cfg_we;
	logic [CfgIdxBits-1:0] cfg_idx;
	logic [CfgDataBits-1:0] cfg_data;

	table_function_interpolator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Items waiting to be offered, and the results predicted for accepted beats.
	tfi_in_t pending_items[$];
	tfi_out_t expected_results[$];
	int err_count = 0;
	int cycle_count = 0;

	// Predictor state: the breakpoint table, the bad-table flag and the registers.
	logic signed [31:0] bp_x[NPTS];
	logic signed [31:0] bp_y[NPTS];
	logic tbl_bad;
	logic mode_step;
	logic [6:0] pts_used;

	// Shadow of the table as the stimulus builds it, used to aim queries.
	logic signed [31:0] gen_x[NPTS];
	int items_made = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, what);
		err_count++;
	endtask

	// Works out the result of one accepted beat and updates the predicted table.
	function automatic tfi_out_t table_lookup(input tfi_in_t it);
		tfi_out_t r;
		int n, lo, hi, mid;
		longint a, d;
		longint unsigned b, q;
		logic signed [31:0] xq, y1, y2;
		r = '0;
		xq = it.x_value;
		if (it.kind == KIND_LOAD) begin
			if (it.point_index == 0)
				tbl_bad = 1'b0;
			else if ($signed(xq) <= $signed(bp_x[it.point_index - 1])) begin
				tbl_bad = 1'b1;
				r.status = ST_BAD;
			end
			bp_x[it.point_index] = xq;
			bp_y[it.point_index] = it.y_value;
			return r;
		end
		n = pts_used;
		if (n > NPTS) begin
			r.status = ST_RANGE;
			return r;
		end
		if (n < 2) begin
			r.status = ST_FEW;
			return r;
		end
		if (tbl_bad) begin
			r.status = ST_BAD;
			return r;
		end
		// Queries at or beyond either end take the end value.
		if ($signed(xq) <= $signed(bp_x[0])) begin
			r.y_result = bp_y[0];
			r.clamped = 1'b1;
			return r;
		end
		if ($signed(bp_x[n - 1]) <= $signed(xq)) begin
			r.y_result = bp_y[n - 1];
			r.interval = 6'(n - 1);
			r.clamped = 1'b1;
			return r;
		end
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if ($signed(bp_x[mid]) <= $signed(xq))
				lo = mid;
			else
				hi = mid;
		end
		y1 = bp_y[lo];
		y2 = bp_y[lo + 1];
		r.interval = 6'(lo);
		if (mode_step) begin
			r.y_result = y1;
			return r;
		end
		// The quotient is floored on the magnitude, so it truncates toward zero.
		a = longint'($signed(xq)) - longint'($signed(bp_x[lo]));
		d = longint'($signed(bp_x[lo + 1])) - longint'($signed(bp_x[lo]));
		if ($signed(y1) <= $signed(y2)) begin
			b = longint'($signed(y2)) - longint'($signed(y1));
			q = (longint'(a) * b) / d;
			r.y_result = y1 + q[31:0];
		end else begin
			b = longint'($signed(y1)) - longint'($signed(y2));
			q = (longint'(a) * b) / d;
			r.y_result = y1 - q[31:0];
		end
		return r;
	endfunction

	// Sender: bursts of beats with random gaps. A beat on offer is held until taken.
	logic beat_taken = 1'b0;
	int gap_left = 0;
	int burst_left = 4;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			beat_taken = 1'b1;
			expected_results.push_back(table_lookup(in_data));
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !beat_taken)) begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					// Zero-length gaps are common so back-to-back beats stay frequent.
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver: a stall pattern picked at random from four kinds, plus one long hold
	// so that the block fills up and pushes back on its input. The hold starts
	// once enough items are queued that the sender keeps offering through it.
	int stall_kind = 0;
	int hold_left = 0;
	int rx_cycles = 0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycles++;
			if (rx_cycles % 64 == 0)
				stall_kind = $urandom_range(0, 3);
			if (!hold_done && rx_cycles >= 3000 && pending_items.size() > 4) begin
				hold_left = 600;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (stall_kind)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Checker: each result beat against the oldest prediction, field by field.
	always @(posedge clk) begin
		tfi_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0)
				report_mismatch("result beat with nothing expected");
			else begin
				want = expected_results.pop_front();
				if (out_data.y_result !== want.y_result)
					report_mismatch($sformatf("y_result %h, expected %h",
						out_data.y_result, want.y_result));
				if (out_data.interval !== want.interval)
					report_mismatch($sformatf("interval %0d, expected %0d",
						out_data.interval, want.interval));
				if (out_data.clamped !== want.clamped)
					report_mismatch($sformatf("clamped %b, expected %b",
						out_data.clamped, want.clamped));
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_data.status, want.status));
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic queue_load(input int idx, input longint xv, input longint yv);
		tfi_in_t it;
		it.kind = KIND_LOAD;
		it.point_index = 6'(idx);
		it.x_value = 32'(xv);
		it.y_value = 32'(yv);
		gen_x[idx] = 32'(xv);
		pending_items.push_back(it);
		items_made++;
	endtask

	// Evaluate beats carry random filler in the fields the block ignores.
	task automatic queue_eval(input longint xv);
		tfi_in_t it;
		it.kind = KIND_EVAL;
		it.point_index = 6'($urandom);
		it.x_value = 32'(xv);
		it.y_value = $urandom;
		pending_items.push_back(it);
		items_made++;
	endtask

	// Register writes happen only with the block idle and its last result drained.
	task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int val);
		while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CfgDataBits'(val);
		if (idx == CFG_INTERP_MODE)
			mode_step = val[0];
		else
			pts_used = 7'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Loads a strictly increasing table of k points. The spacing scale sets how
	// close neighbors sit: up to 4, 1024 or 2^25 LSBs apart.
	task automatic load_table(input int k, input int spacing);
		longint maxstep, base, xv;
		maxstep = (spacing == 0) ? 4 : (spacing == 1) ? 1024 : 64'd33554432;
		base = longint'(-2147483648) +
			longint'($urandom_range(0, 32'hFFFFFFFF - 32'(k * maxstep)));
		xv = base;
		for (int i = 0; i < k; i++) begin
			queue_load(i, xv, longint'($signed($urandom)));
			xv = xv + 1 + longint'($urandom_range(0, 32'(maxstep - 1)));
		end
	endtask

	// Picks a query aimed at the loaded table: off either end, on a breakpoint,
	// or inside an interval; now and then anywhere in the range.
	function automatic longint pick_query();
		int n, j, pick;
		longint lo, hi;
		n = (pts_used > NPTS) ? NPTS : pts_used;
		pick = $urandom_range(0, 9);
		if (n < 2 || pick == 0)
			return longint'($signed($urandom));
		if (pick == 1)
			return longint'($signed(gen_x[0])) - $urandom_range(0, 2);
		if (pick == 2)
			return longint'($signed(gen_x[n - 1])) + $urandom_range(0, 2);
		j = $urandom_range(0, n - 2);
		if (pick == 3)
			return longint'($signed(gen_x[j]));
		lo = longint'($signed(gen_x[j]));
		hi = longint'($signed(gen_x[j + 1]));
		if (hi <= lo + 1)
			return lo;
		return lo + 1 + longint'($urandom) % (hi - lo - 1);
	endfunction

	initial begin
		int k, n_evals;
		tbl_bad = 1'b0;
		mode_step = 1'b0;
		pts_used = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: too few points with an empty table, which reads nothing.
		queue_eval(0);
		write_reg(CFG_POINTS_IN_USE, 1);
		queue_eval(-1);

		// A full table spanning the whole x range with y swinging between extremes.
		for (int i = 0; i < NPTS; i++)
			queue_load(i, longint'(-2147483648) + (longint'(i) * 64'd4294967295) / 63,
				(i % 2 == 0) ? 64'sd2147483647 : -64'sd2147483648);
		write_reg(CFG_POINTS_IN_USE, NPTS);
		queue_eval(-2147483648);
		queue_eval(2147483647);
		queue_eval(longint'($signed(gen_x[10])));
		queue_eval(longint'($signed(gen_x[10])) + 1);
		queue_eval(longint'($signed(gen_x[11])) - 1);
		queue_eval(longint'($signed(gen_x[32])) + 12345);
		write_reg(CFG_INTERP_MODE, 1);
		queue_eval(longint'($signed(gen_x[5])) + 777);
		queue_eval(longint'($signed(gen_x[62])) + 3);

		// An x equal to its left neighbor marks the table bad until index 0 reloads.
		queue_load(20, longint'($signed(gen_x[19])), 5);
		queue_eval(0);
		queue_load(0, -2147483648, 100);
		queue_load(1, -2147483647, -100);
		write_reg(CFG_POINTS_IN_USE, 2);
		queue_eval(0);
		write_reg(CFG_INTERP_MODE, 0);
		queue_eval(-2147483648);
		queue_eval(-2147483647);
		write_reg(CFG_POINTS_IN_USE, 127);
		queue_eval(0);

		// Random phases: mostly well-formed tables with aimed queries, some
		// stale or corrupted tables and arbitrary point counts.
		while (items_made < ITEM_TARGET) begin
			write_reg(CFG_INTERP_MODE, ($urandom_range(0, 3) == 0));
			k = ($urandom_range(0, 5) == 0) ? NPTS : $urandom_range(2, 12);
			case ($urandom_range(0, 9))
				0: write_reg(CFG_POINTS_IN_USE, $urandom_range(0, 1));
				1: write_reg(CFG_POINTS_IN_USE, $urandom_range(2, NPTS));
				2: write_reg(CFG_POINTS_IN_USE, NPTS);
				default: write_reg(CFG_POINTS_IN_USE, k);
			endcase
			if ($urandom_range(0, 4) != 0)
				load_table(k, $urandom_range(0, 2));
			n_evals = $urandom_range(8, 30);
			for (int e = 0; e < n_evals; e++) begin
				if ($urandom_range(0, 40) == 0) begin
					// Corrupt one slot: x at or below its left neighbor.
					k = $urandom_range(1, NPTS - 1);
					queue_load(k, longint'($signed(gen_x[k - 1])) - $urandom_range(0, 3),
						longint'($signed($urandom)));
				end
				queue_eval(pick_query());
			end
		end

		while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/tfi_pkg.sv
hdl/tfi_mem.sv
hdl/tfi_div.sv
hdl/tfi_seq.sv
hdl/table_function_interpolator_top.sv
test/table_function_interpolator_top_tb.sv
